>>> rtl/nvqp_pkg.sv
package nvqp_pkg;

  localparam int unsigned ID_W     = 6;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned QID_W    = 16;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned CODE_W   = 15;
  localparam int unsigned STS_W    = 3;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 16;

  // Item kinds carried in tuser.
  localparam logic [KIND_W-1:0] KIND_GET    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SUBMIT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CQE    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_PUT    = 2'd3;

  // Result status codes.
  localparam logic [STS_W-1:0] STS_OK      = 3'd0;
  localparam logic [STS_W-1:0] STS_NO_ID   = 3'd1;
  localparam logic [STS_W-1:0] STS_STALE   = 3'd2;
  localparam logic [STS_W-1:0] STS_BAD     = 3'd3;
  localparam logic [STS_W-1:0] STS_FOREIGN = 3'd4;

  // Per-id life cycle.
  localparam logic [1:0] ID_AVAIL  = 2'd0;
  localparam logic [1:0] ID_ALLOC  = 2'd1;
  localparam logic [1:0] ID_SUBMIT = 2'd2;
  localparam logic [1:0] ID_DONE   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_ENTRIES = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_SUBQ_ID   = 4'd1;

  typedef struct packed {
    logic capture;  // latch an accepted item and read both memories
    logic commit;   // resolve the item, update state, load the result register
    logic init;     // queue size written: reinitialise the pair
    logic own_we;   // own submission queue id written
  } nvqp_cmd_t;

endpackage

>>> rtl/nvqp_ctrl.sv
module nvqp_ctrl
  import nvqp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  output nvqp_cmd_t            cmd
);

  typedef enum logic {
    S_IDLE,
    S_RESOLVE
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   accept;
  logic   commit;
  logic   pop;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  // The result register must be free, or be emptied in this cycle, before a commit.
  assign commit     = (state_r == S_RESOLVE) && (!out_valid_r || out_tready);
  assign pop        = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd.capture = accept;
    cmd.commit  = commit;
    cmd.init    = cfg_valid && (cfg_index == REG_QUEUE_ENTRIES);
    cmd.own_we  = cfg_valid && (cfg_index == REG_OWN_SUBQ_ID);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_RESOLVE;
          end
        end
        S_RESOLVE: begin
          if (commit) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/nvqp_dp.sv
module nvqp_dp
  import nvqp_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  nvqp_cmd_t            cmd,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [ID_W-1:0]      in_cmd_id,
  input  logic [QID_W-1:0]     in_entry_subq_id,
  input  logic [WORD_W-1:0]    in_entry_status,
  output logic [STS_W-1:0]     out_result_status,
  output logic [ID_W-1:0]      out_granted_id,
  output logic                 out_doorbell_valid,
  output logic [ID_W-1:0]      out_doorbell_value,
  output logic [CODE_W-1:0]    out_completion_code,
  output logic                 out_requeue_signal
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] MIN_N   = CNT_W'(2);

  // Memories: entries that were never written since the last reinitialise read as
  // their reset value, tracked by one valid bit per entry.
  logic [ID_W-1:0] stack_mem [DEPTH];
  logic [1:0]      idst_mem  [DEPTH];
  logic [DEPTH-1:0] stack_vld_r;
  logic [DEPTH-1:0] idst_vld_r;

  // Configuration and queue state.
  logic [CNT_W-1:0] n_r;
  logic [QID_W-1:0] own_r;
  logic [CNT_W-1:0] free_cnt_r;
  logic [ID_W-1:0]  tail_r;
  logic [ID_W-1:0]  head_r;
  logic             phase_r;
  logic             rq_pend_r;

  // Captured item and registered memory reads.
  logic [KIND_W-1:0] kind_r;
  logic [ID_W-1:0]   id_r;
  logic [QID_W-1:0]  esq_r;
  logic [WORD_W-1:0] est_r;
  logic [ID_W-1:0]   stack_q_r;
  logic              stack_qv_r;
  logic [AW-1:0]     stack_qa_r;
  logic [1:0]        idst_q_r;
  logic              idst_qv_r;

  logic [AW-1:0]    stack_raddr;
  logic [CNT_W-1:0] fc_dec;
  logic [ID_W-1:0]  top_id;
  logic [1:0]       cur_st;
  logic             id_oob;
  logic [CNT_W-1:0] tail_inc;
  logic [CNT_W-1:0] head_inc;
  logic [CNT_W-1:0] cfg_n;

  // Resolved next values.
  logic [STS_W-1:0]  sts;
  logic [ID_W-1:0]   granted;
  logic              dbv;
  logic [ID_W-1:0]   dbval;
  logic [CODE_W-1:0] code;
  logic              rq;
  logic [CNT_W-1:0]  free_cnt_nxt;
  logic [ID_W-1:0]   tail_nxt;
  logic [ID_W-1:0]   head_nxt;
  logic              phase_nxt;
  logic              rq_pend_nxt;
  logic              stack_we;
  logic              idst_we;
  logic [AW-1:0]     idst_waddr;
  logic [1:0]        idst_wdata;

  assign fc_dec      = free_cnt_r - CNT_W'(1);
  assign stack_raddr = fc_dec[AW-1:0];
  assign top_id      = stack_qv_r ? stack_q_r : ID_W'(stack_qa_r);
  assign cur_st      = idst_qv_r ? idst_q_r : ID_AVAIL;
  assign id_oob      = ({1'b0, id_r} >= n_r);
  assign tail_inc    = {1'b0, tail_r} + CNT_W'(1);
  assign head_inc    = {1'b0, head_r} + CNT_W'(1);

  always_comb begin
    if (cfg_data[CNT_W-1:0] < MIN_N) begin
      cfg_n = MIN_N;
    end else if (cfg_data[CNT_W-1:0] > DEPTH_C) begin
      cfg_n = DEPTH_C;
    end else begin
      cfg_n = cfg_data[CNT_W-1:0];
    end
  end

  always_comb begin
    sts          = STS_OK;
    granted      = '0;
    dbv          = 1'b0;
    dbval        = '0;
    code         = '0;
    rq           = 1'b0;
    free_cnt_nxt = free_cnt_r;
    tail_nxt     = tail_r;
    head_nxt     = head_r;
    phase_nxt    = phase_r;
    rq_pend_nxt  = rq_pend_r;
    stack_we     = 1'b0;
    idst_we      = 1'b0;
    idst_waddr   = id_r[AW-1:0];
    idst_wdata   = ID_AVAIL;
    unique case (kind_r)
      KIND_GET: begin
        if (free_cnt_r == '0 || free_cnt_r > n_r) begin
          rq_pend_nxt = 1'b1;
          sts         = STS_NO_ID;
        end else begin
          free_cnt_nxt = fc_dec;
          granted      = top_id;
          idst_waddr   = top_id[AW-1:0];
          idst_wdata   = ID_ALLOC;
          idst_we      = ({1'b0, top_id} < n_r);
        end
      end
      KIND_SUBMIT: begin
        if (id_oob || cur_st != ID_ALLOC) begin
          sts = STS_BAD;
        end else begin
          tail_nxt   = (tail_inc >= n_r) ? '0 : tail_inc[ID_W-1:0];
          idst_we    = 1'b1;
          idst_wdata = ID_SUBMIT;
          dbv        = 1'b1;
          dbval      = tail_nxt;
        end
      end
      KIND_CQE: begin
        if (est_r[0] != phase_r) begin
          sts = STS_STALE;
        end else begin
          // A fresh entry is always consumed, whatever it names.
          if (head_inc >= n_r) begin
            head_nxt  = '0;
            phase_nxt = ~phase_r;
          end else begin
            head_nxt = head_inc[ID_W-1:0];
          end
          dbv   = 1'b1;
          dbval = head_nxt;
          if (esq_r != own_r) begin
            sts = STS_FOREIGN;
          end else if (id_oob || cur_st != ID_SUBMIT) begin
            sts = STS_BAD;
          end else begin
            idst_we    = 1'b1;
            idst_wdata = ID_DONE;
            code       = est_r[WORD_W-1:1];
          end
        end
      end
      KIND_PUT: begin
        if (id_oob || cur_st != ID_DONE) begin
          sts = STS_BAD;
        end else begin
          idst_we    = 1'b1;
          idst_wdata = ID_AVAIL;
          if (free_cnt_r < n_r) begin
            stack_we     = 1'b1;
            free_cnt_nxt = free_cnt_r + CNT_W'(1);
          end
          rq          = rq_pend_r;
          rq_pend_nxt = 1'b0;
        end
      end
      default: sts = STS_OK;
    endcase
  end

  // Memory ports: one read each at capture, one write each at commit.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      stack_q_r <= stack_mem[stack_raddr];
      idst_q_r  <= idst_mem[in_cmd_id[AW-1:0]];
    end
    if (cmd.commit && stack_we) begin
      stack_mem[free_cnt_r[AW-1:0]] <= id_r;
    end
    if (cmd.commit && idst_we) begin
      idst_mem[idst_waddr] <= idst_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r     <= in_kind;
      id_r       <= in_cmd_id;
      esq_r      <= in_entry_subq_id;
      est_r      <= in_entry_status;
      stack_qv_r <= stack_vld_r[stack_raddr];
      stack_qa_r <= stack_raddr;
      idst_qv_r  <= idst_vld_r[in_cmd_id[AW-1:0]];
    end
    if (cmd.commit) begin
      out_result_status   <= sts;
      out_granted_id      <= granted;
      out_doorbell_valid  <= dbv;
      out_doorbell_value  <= dbval;
      out_completion_code <= code;
      out_requeue_signal  <= rq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= DEPTH_C;
      own_r       <= '0;
      free_cnt_r  <= DEPTH_C;
      tail_r      <= '0;
      head_r      <= '0;
      phase_r     <= 1'b1;
      rq_pend_r   <= 1'b0;
      stack_vld_r <= '0;
      idst_vld_r  <= '0;
    end else begin
      if (cmd.own_we) begin
        own_r <= cfg_data;
      end
      if (cmd.init) begin
        n_r         <= cfg_n;
        free_cnt_r  <= cfg_n;
        tail_r      <= '0;
        head_r      <= '0;
        phase_r     <= 1'b1;
        rq_pend_r   <= 1'b0;
        stack_vld_r <= '0;
        idst_vld_r  <= '0;
      end else if (cmd.commit) begin
        free_cnt_r <= free_cnt_nxt;
        tail_r     <= tail_nxt;
        head_r     <= head_nxt;
        phase_r    <= phase_nxt;
        rq_pend_r  <= rq_pend_nxt;
        if (stack_we) begin
          stack_vld_r[free_cnt_r[AW-1:0]] <= 1'b1;
        end
        if (idst_we) begin
          idst_vld_r[idst_waddr] <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/nvme_queue_pair_command_tracker.sv
// Command id and ring tracker for one NVMe submission/completion queue pair.
// The in_ channel takes one event per beat: tuser is the kind (get id, submit,
// completion entry, put id) and tdata carries the id and the completion fields.
// The out_ channel returns exactly one result beat per event: status, granted id,
// doorbell write request and value, completion code and requeue flag.
// The cfg_ channel writes the queue size (index 0) or own queue id (index 1);
// it is always ready and is to be used only while no event is in flight.
// Writing the queue size restarts the pair as after reset, with that size; the own queue id is kept.
// Each event passes a capture step, which reads the free-id stack and the per-id
// state memory, and a resolve step, which resolves it and writes them back. The
// result beat is registered when the resolve step commits; a new event is taken
// only after the previous one has been resolved.
// The input accepts the next event while a result still waits; if the receiver
// stalls, that event is held in its resolve step until the result is taken.
// Reset restores a full stack with the highest id on top, every id free, tail
// and head at zero and the expected phase at one; no clearing pass is needed.
module nvme_queue_pair_command_tracker
  import nvqp_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [39:0]          in_tdata,  // cmd_id[5:0], entry_subq_id[21:6],
                                          // entry_status[37:22], zero [39:38]
  input  logic [KIND_W-1:0]    in_tuser,  // kind[1:0]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata, // result_status[2:0], granted_id[8:3],
                                          // doorbell_valid[9], doorbell_value[15:10],
                                          // completion_code[30:16], requeue_signal[31]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int unsigned DEPTH = (MAX_ENTRIES < 64) ? MAX_ENTRIES : 64;

  nvqp_cmd_t         cmd;
  logic [STS_W-1:0]  res_sts;
  logic [ID_W-1:0]   res_gid;
  logic              res_dbv;
  logic [ID_W-1:0]   res_dbval;
  logic [CODE_W-1:0] res_code;
  logic              res_rq;

  assign cfg_ready = 1'b1;

  nvqp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cmd        (cmd)
  );

  nvqp_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .cfg_data            (cfg_data),
    .in_kind             (in_tuser),
    .in_cmd_id           (in_tdata[5:0]),
    .in_entry_subq_id    (in_tdata[21:6]),
    .in_entry_status     (in_tdata[37:22]),
    .out_result_status   (res_sts),
    .out_granted_id      (res_gid),
    .out_doorbell_valid  (res_dbv),
    .out_doorbell_value  (res_dbval),
    .out_completion_code (res_code),
    .out_requeue_signal  (res_rq)
  );

  assign out_tdata = {res_rq, res_code, res_dbval, res_dbv, res_gid, res_sts};

endmodule
